/* rtl/m3i_pkg.sv */
// ----------------------------------------------------------------------------
// m3i_pkg: shared constants and types for the 3x3 matrix inverse
// Fixed-point format, datapath widths and pipeline depth.
// ----------------------------------------------------------------------------
package m3i_pkg;

  // fraction bits of the Q format on both sides
  localparam int FRAC_BITS = 16;

  // element width on the streams
  localparam int EW = 32;
  // cofactor width (difference of two 64-bit products)
  localparam int CW = 2 * EW + 1;
  // signed determinant width and its magnitude width
  localparam int DW = 98;
  localparam int MW = DW - 1;
  // quotient bits produced by the divider
  localparam int QB = 32;
  // scaled numerator width and divider remainder width
  localparam int NW = 2 * EW + 2 * FRAC_BITS;
  localparam int RW = (NW > MW + QB) ? NW : MW + QB;

  // front stages before the divider, and total register stages
  localparam int NFRONT = 5;
  localparam int NSTG   = NFRONT + QB + 1;

  typedef logic signed [EW-1:0] elem_t;

  // one divider lane beat: scaled numerator, divisor and side flags
  typedef struct packed {
    logic [RW-1:0] num;
    logic [MW-1:0] den;
    logic          neg;
    logic          clip;
  } div_in_t;

  typedef struct packed {
    logic [QB-1:0] quo;
    logic          neg;
    logic          clip;
  } div_out_t;

endpackage

/* rtl/m3i_div.sv */
// ----------------------------------------------------------------------------
// m3i_div: pipelined restoring divider lane
// One quotient bit per register stage, most significant bit first.
// ----------------------------------------------------------------------------
module m3i_div
  import m3i_pkg::*;
(
  input  logic     clk_i,
  input  logic     en_i,
  input  div_in_t  din_i,
  output div_out_t dout_o
);

  logic [RW-1:0] rem_q [QB];
  logic [MW-1:0] den_q [QB];
  logic [QB-1:0] quo_q [QB];
  logic          neg_q [QB];
  logic          clip_q[QB];

  for (genvar s = 0; s < QB; s++) begin : g_stg
    logic [RW-1:0] rem_in;
    logic [MW-1:0] den_in;
    logic [QB-1:0] quo_in;
    logic          neg_in;
    logic          clip_in;
    logic [RW:0]   diff;

    // select previous stage or lane input
    if (s == 0) begin : g_first
      assign rem_in  = din_i.num;
      assign den_in  = din_i.den;
      assign quo_in  = '0;
      assign neg_in  = din_i.neg;
      assign clip_in = din_i.clip;
    end else begin : g_next
      assign rem_in  = rem_q[s-1];
      assign den_in  = den_q[s-1];
      assign quo_in  = quo_q[s-1];
      assign neg_in  = neg_q[s-1];
      assign clip_in = clip_q[s-1];
    end

    // trial subtract of the divisor at this bit weight
    assign diff = {1'b0, rem_in} - ({1'b0, RW'(den_in)} << (QB - 1 - s));

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[s]  <= diff[RW] ? rem_in : diff[RW-1:0];
        den_q[s]  <= den_in;
        quo_q[s]  <= {quo_in[QB-2:0], ~diff[RW]};
        neg_q[s]  <= neg_in;
        clip_q[s] <= clip_in;
      end
    end
  end

  assign dout_o.quo  = quo_q[QB-1];
  assign dout_o.neg  = neg_q[QB-1];
  assign dout_o.clip = clip_q[QB-1];

endmodule

/* rtl/matrix3_inverse.sv */
// ----------------------------------------------------------------------------
// matrix3_inverse: pipelined 3x3 matrix inverse in signed fixed point
// Adjugate from row cross products, determinant, and one exact truncating
// division per element with saturation to 32 bits.
// ----------------------------------------------------------------------------
//  channel   dir  tdata                        tuser
//  s_axis    in   a00..a22, 9 x 32 bits        -
//  m_axis    out  b00..b22, 9 x 32 bits        singular, clipped
//
//  One beat enters and one leaves every cycle while m_axis is not stalled.
//  Depth is set by 5 front stages (products, cofactors, determinant
//  partials, determinant, scaling), the 32-stage divider and the output.
//  Reset clears only the stage valid bits.
//  A stall on m_axis freezes every stage; s_axis_tready drops with it.
// ----------------------------------------------------------------------------
module matrix3_inverse
  import m3i_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            s_axis_tvalid,
  output logic            s_axis_tready,
  input  logic [9*EW-1:0] s_axis_tdata,  // a00, a01, a02, a10, ... a22
  output logic            m_axis_tvalid,
  input  logic            m_axis_tready,
  output logic [9*EW-1:0] m_axis_tdata,  // b00, b01, b02, b10, ... b22
  output logic [1:0]      m_axis_tuser   // singular, clipped
);

  logic              en;
  logic [NSTG-1:0]   vld_q;

  elem_t             m_in [3][3];
  logic signed [2*EW-1:0] prod_q [3][3][2];
  elem_t             r0a_q [3];
  elem_t             r0b_q [3];
  logic signed [CW-1:0] cof_q  [3][3];
  logic signed [CW-1:0] cofb_q [3][3];
  logic signed [CW-1:0] plo_q [3];
  logic signed [CW-1:0] phi_q [3];
  logic signed [CW-1:0] cofc_q [3][3];
  logic signed [DW-1:0] det_q;
  div_in_t           dvi_q [3][3];
  div_out_t          dvo   [3][3];
  logic              sing5_q;
  logic              sing_q [QB];
  logic [EW-1:0]     res_d [3][3];
  logic [EW-1:0]     res_q [3][3];
  logic              clip_d;
  logic              sing_out_q;
  logic              clip_out_q;

  // advance the whole pipeline unless the output beat is held
  assign en            = ~vld_q[NSTG-1] | m_axis_tready;
  assign s_axis_tready = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[NSTG-2:0], s_axis_tvalid};
    end
  end

  // unpack input elements
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        m_in[r][c] = s_axis_tdata[(r*3+c)*EW +: EW];
      end
    end
  end

  // stage 1: the 18 element products of the cross products
  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int j = 0; j < 3; j++) begin
        for (int i = 0; i < 3; i++) begin
          prod_q[j][i][0] <= m_in[(j+1)%3][(i+1)%3] * m_in[(j+2)%3][(i+2)%3];
          prod_q[j][i][1] <= m_in[(j+1)%3][(i+2)%3] * m_in[(j+2)%3][(i+1)%3];
        end
      end
      for (int i = 0; i < 3; i++) r0a_q[i] <= m_in[0][i];
    end
  end

  // stage 2: cofactors, cof[j][i] = component i of row cross product j
  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int j = 0; j < 3; j++) begin
        for (int i = 0; i < 3; i++) begin
          cof_q[j][i] <= {prod_q[j][i][0][2*EW-1], prod_q[j][i][0]}
                       - {prod_q[j][i][1][2*EW-1], prod_q[j][i][1]};
        end
      end
      for (int i = 0; i < 3; i++) r0b_q[i] <= r0a_q[i];
    end
  end

  // stage 3: split row 0 dot cofactors into 32 x 33 bit partials
  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        plo_q[i] <= r0b_q[i] * $signed({1'b0, cof_q[0][i][EW-1:0]});
        phi_q[i] <= r0b_q[i] * $signed(cof_q[0][i][CW-1:EW]);
      end
      cofb_q <= cof_q;
    end
  end

  // stage 4: determinant
  always_ff @(posedge clk_i) begin
    if (en) begin
      det_q <= ((DW'(phi_q[0]) + DW'(phi_q[1]) + DW'(phi_q[2])) <<< EW)
             + DW'(plo_q[0]) + DW'(plo_q[1]) + DW'(plo_q[2]);
      cofc_q <= cofb_q;
    end
  end

  // stage 5: magnitudes, scaled numerators and the overflow pre-check
  always_ff @(posedge clk_i) begin
    logic signed [DW-1:0] ndet;
    logic [MW-1:0]        dmag;
    logic signed [CW-1:0] ncof;
    logic [2*EW-1:0]      cmag;
    logic [RW-1:0]        num;
    if (en) begin
      ndet = -det_q;
      dmag = det_q[DW-1] ? ndet[MW-1:0] : det_q[MW-1:0];
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          ncof = -cofc_q[j][i];
          cmag = cofc_q[j][i][CW-1] ? ncof[2*EW-1:0] : cofc_q[j][i][2*EW-1:0];
          num  = RW'(cmag) << (2 * FRAC_BITS);
          dvi_q[i][j].num  <= num;
          dvi_q[i][j].den  <= dmag;
          dvi_q[i][j].neg  <= cofc_q[j][i][CW-1] ^ det_q[DW-1];
          dvi_q[i][j].clip <= num >= (RW'(dmag) << QB);
        end
      end
      sing5_q <= (det_q == '0);
    end
  end

  // divider lanes, one per inverse element
  for (genvar i = 0; i < 3; i++) begin : g_row
    for (genvar j = 0; j < 3; j++) begin : g_col
      m3i_div u_div (
        .clk_i  (clk_i),
        .en_i   (en),
        .din_i  (dvi_q[i][j]),
        .dout_o (dvo[i][j])
      );
    end
  end

  // carry the singular flag alongside the divider
  always_ff @(posedge clk_i) begin
    if (en) begin
      sing_q[0] <= sing5_q;
      for (int s = 1; s < QB; s++) sing_q[s] <= sing_q[s-1];
    end
  end

  // saturate and sign each quotient
  always_comb begin
    logic ovf;
    logic [QB-1:0] nq;
    clip_d = 1'b0;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        nq = -dvo[i][j].quo;
        if (dvo[i][j].neg) begin
          ovf = dvo[i][j].clip || (dvo[i][j].quo > {1'b1, {(QB-1){1'b0}}});
          res_d[i][j] = ovf ? {1'b1, {(EW-1){1'b0}}} : nq;
        end else begin
          ovf = dvo[i][j].clip || dvo[i][j].quo[QB-1];
          res_d[i][j] = ovf ? {1'b0, {(EW-1){1'b1}}} : dvo[i][j].quo;
        end
        if (sing_q[QB-1]) begin
          res_d[i][j] = '0;
          ovf         = 1'b0;
        end
        clip_d = clip_d | ovf;
      end
    end
  end

  // output register
  always_ff @(posedge clk_i) begin
    if (en) begin
      res_q      <= res_d;
      sing_out_q <= sing_q[QB-1];
      clip_out_q <= clip_d;
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        m_axis_tdata[(i*3+j)*EW +: EW] = res_q[i][j];
      end
    end
  end

  assign m_axis_tvalid = vld_q[NSTG-1];
  assign m_axis_tuser  = {clip_out_q, sing_out_q};

  // a singular result carries all zeros and no clip
  a_sing_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser[0]) |-> (m_axis_tdata == '0 && !m_axis_tuser[1]))
    else $error("singular result not cleared");

  // an accepted beat enters the first stage
  a_enter: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> vld_q[0])
    else $error("accepted beat lost at entry");

endmodule
